[sv/fpa_pkg.sv]
// ============================================================================
// fpa_pkg
// Shared types and constants for the fixed-point ALU.
// ============================================================================
package fpa_pkg;

    typedef enum logic [3:0] {
        CMD_ADD      = 4'd0,
        CMD_SUB      = 4'd1,
        CMD_MUL      = 4'd2,
        CMD_DIV      = 4'd3,
        CMD_GT       = 4'd4,
        CMD_LT       = 4'd5,
        CMD_GE       = 4'd6,
        CMD_LE       = 4'd7,
        CMD_EQ       = 4'd8,
        CMD_NE       = 4'd9,
        CMD_MAX      = 4'd10,
        CMD_MIN      = 4'd11,
        CMD_INC      = 4'd12,
        CMD_DEC      = 4'd13,
        CMD_FROM_INT = 4'd14,
        CMD_TO_INT   = 4'd15
    } cmd_t;

    typedef enum logic [1:0] {
        UNIT_ALU = 2'd0,
        UNIT_MUL = 2'd1,
        UNIT_DIV = 2'd2
    } unit_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_DIV_ZERO = 2'd1,
        ST_SAT      = 2'd2
    } status_t;

    typedef struct packed {
        cmd_t  cmd;
        unit_t unit;
    } item_t;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;
    localparam int OPND_W      = 32;

endpackage

[sv/fpa_front.sv]
// ============================================================================
// fpa_front
// Accepts commands, decodes the opcode into an execution unit class.
// ============================================================================
module fpa_front
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     accept,
    input  logic [3:0]               cmd,
    input  logic [fpa_pkg::OPND_W-1:0] operand_a,
    input  logic [fpa_pkg::OPND_W-1:0] operand_b,
    output logic                     push,
    output fpa_pkg::item_t           push_item,
    output logic [fpa_pkg::OPND_W-1:0] push_a,
    output logic [fpa_pkg::OPND_W-1:0] push_b
);

    logic                       fv_reg;
    fpa_pkg::item_t             item_reg;
    fpa_pkg::item_t             item_next;
    logic [fpa_pkg::OPND_W-1:0] a_reg;
    logic [fpa_pkg::OPND_W-1:0] b_reg;

    always_comb
    begin
        item_next.cmd = fpa_pkg::cmd_t'(cmd);
        case (fpa_pkg::cmd_t'(cmd))
            fpa_pkg::CMD_MUL: item_next.unit = fpa_pkg::UNIT_MUL;
            fpa_pkg::CMD_DIV: item_next.unit = fpa_pkg::UNIT_DIV;
            default:          item_next.unit = fpa_pkg::UNIT_ALU;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fv_reg <= 1'b0;
        end
        else
        begin
            fv_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item_next;
            a_reg    <= operand_a;
            b_reg    <= operand_b;
        end
    end

    assign push      = fv_reg;
    assign push_item = item_reg;
    assign push_a    = a_reg;
    assign push_b    = b_reg;

endmodule

[sv/fpa_queue.sv]
// ============================================================================
// fpa_queue
// Short word queue between the decode front and the execute back.
// ============================================================================
module fpa_queue
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    input  fpa_pkg::item_t               push_item,
    input  logic [fpa_pkg::OPND_W-1:0]   push_a,
    input  logic [fpa_pkg::OPND_W-1:0]   push_b,
    output logic                         pop,
    output fpa_pkg::item_t               pop_item,
    output logic [fpa_pkg::OPND_W-1:0]   pop_a,
    output logic [fpa_pkg::OPND_W-1:0]   pop_b,
    output logic [fpa_pkg::QCNT_W-1:0]   level
);

    localparam int EW = $bits(fpa_pkg::item_t) + 2 * fpa_pkg::OPND_W;

    logic [EW-1:0]                 mem [fpa_pkg::QUEUE_DEPTH];
    logic [fpa_pkg::QPTR_W-1:0]    wr_ptr_reg;
    logic [fpa_pkg::QPTR_W-1:0]    rd_ptr_reg;
    logic [fpa_pkg::QCNT_W-1:0]    count_reg;
    logic [fpa_pkg::QCNT_W-1:0]    count_next;
    logic [EW-1:0]                 rd_word;

    // the back never stalls: drain one word every cycle there is one
    assign pop     = (count_reg != '0);
    assign rd_word = mem[rd_ptr_reg];
    assign pop_item = fpa_pkg::item_t'(rd_word[EW-1 -: $bits(fpa_pkg::item_t)]);
    assign pop_a   = rd_word[2*fpa_pkg::OPND_W-1 -: fpa_pkg::OPND_W];
    assign pop_b   = rd_word[fpa_pkg::OPND_W-1:0];
    assign level   = count_reg;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (!push && pop)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= {push_item, push_a, push_b};
    end

endmodule

[sv/fpa_div.sv]
// ============================================================================
// fpa_div
// Pipelined restoring divider, one quotient bit per stage.
// ============================================================================
module fpa_div #(
    parameter int NW = 42
)
(
    input  logic          clk,
    input  logic [NW-1:0] num,
    input  logic [32:0]   den,
    output logic [NW-1:0] quot
);

    logic [32:0]   rem_reg [NW];
    logic [NW-1:0] nq_reg  [NW];
    logic [32:0]   den_reg [NW];

    genvar i;
    generate
        for (i = 0; i < NW; i++)
        begin : g_stage
            logic [32:0]   rem_in;
            logic [NW-1:0] nq_in;
            logic [32:0]   den_in;
            logic [33:0]   shifted;
            logic [33:0]   diff;

            if (i == 0)
            begin : g_first
                assign rem_in = '0;
                assign nq_in  = num;
                assign den_in = den;
            end
            else
            begin : g_next
                assign rem_in = rem_reg[i-1];
                assign nq_in  = nq_reg[i-1];
                assign den_in = den_reg[i-1];
            end

            assign shifted = {rem_in, nq_in[NW-1]};
            assign diff    = shifted - {1'b0, den_in};

            always_ff @(posedge clk)
            begin
                den_reg[i] <= den_in;
                if (shifted >= {1'b0, den_in})
                begin
                    rem_reg[i] <= diff[32:0];
                    nq_reg[i]  <= {nq_in[NW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[i] <= shifted[32:0];
                    nq_reg[i]  <= {nq_in[NW-2:0], 1'b0};
                end
            end
        end
    endgenerate

    assign quot = nq_reg[NW-1];

endmodule

[sv/fpa_back.sv]
// ============================================================================
// fpa_back
// Execute pipeline: simple ops, multiplier and divider, rounding and
// saturation, aligned to the divider depth.
// ============================================================================
module fpa_back #(
    parameter int FRAC_BITS  = 8,
    parameter int WORD_WIDTH = 32
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         pop,
    input  fpa_pkg::item_t               pop_item,
    input  logic [fpa_pkg::OPND_W-1:0]   pop_a,
    input  logic [fpa_pkg::OPND_W-1:0]   pop_b,
    output logic                         out_valid,
    output logic [fpa_pkg::OPND_W-1:0]   out_res,
    output logic                         out_cmp,
    output fpa_pkg::status_t             out_stat
);

    localparam int W  = WORD_WIDTH;
    localparam int F  = FRAC_BITS;
    localparam int NW = 34 + F;
    localparam int DL = NW;
    localparam logic [63:0] HALF = (F > 0) ? (64'd1 << (F - 1)) : 64'd0;
    localparam logic [63:0] LIM  = 64'd1 << (W - 1);
    localparam logic [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};
    localparam logic [W-1:0] WMAX = ~WMIN;

    function automatic logic [W:0] sat_fn(input logic [63:0] q, input logic neg);
        logic [63:0] nq;
        begin
            nq = 64'd0 - q;
            if (neg)
            begin
                if (q > LIM)
                    sat_fn = {1'b1, WMIN};
                else
                    sat_fn = {1'b0, nq[W-1:0]};
            end
            else
            begin
                if (q >= LIM)
                    sat_fn = {1'b1, WMAX};
                else
                    sat_fn = {1'b0, q[W-1:0]};
            end
        end
    endfunction

    // ---------------- E1: operand reduction and simple ops ----------------
    logic [63:0]        a64, b64;
    logic [W-1:0]       aw, bw;
    logic signed [63:0] ax, bx;
    logic [32:0]        a33, b33, na33, nb33;
    logic [31:0]        ma, mb;
    logic               sa, sb;
    logic [W-1:0]       res_e1;
    fpa_pkg::status_t   stat_e1;
    logic               cmp_e1;
    logic signed [W+F-1:0] fi_wv;
    logic [F:0]         fi_top;

    always_comb
    begin
        a64  = {{32{pop_a[31]}}, pop_a};
        b64  = {{32{pop_b[31]}}, pop_b};
        aw   = a64[W-1:0];
        bw   = b64[W-1:0];
        ax   = 64'($signed(aw));
        bx   = 64'($signed(bw));
        a33  = ax[32:0];
        b33  = bx[32:0];
        na33 = 33'd0 - a33;
        nb33 = 33'd0 - b33;
        sa   = a33[32];
        sb   = b33[32];
        ma   = sa ? na33[31:0] : a33[31:0];
        mb   = sb ? nb33[31:0] : b33[31:0];
        fi_wv  = (W+F)'($signed(aw)) <<< F;
        fi_top = fi_wv[W+F-1:W-1];

        res_e1  = '0;
        stat_e1 = fpa_pkg::ST_OK;
        cmp_e1  = 1'b0;
        case (pop_item.cmd)
            fpa_pkg::CMD_ADD: res_e1 = aw + bw;
            fpa_pkg::CMD_SUB: res_e1 = aw - bw;
            fpa_pkg::CMD_GT:  cmp_e1 = ($signed(aw) >  $signed(bw));
            fpa_pkg::CMD_LT:  cmp_e1 = ($signed(aw) <  $signed(bw));
            fpa_pkg::CMD_GE:  cmp_e1 = ($signed(aw) >= $signed(bw));
            fpa_pkg::CMD_LE:  cmp_e1 = ($signed(aw) <= $signed(bw));
            fpa_pkg::CMD_EQ:  cmp_e1 = (aw == bw);
            fpa_pkg::CMD_NE:  cmp_e1 = (aw != bw);
            fpa_pkg::CMD_MAX: res_e1 = ($signed(aw) > $signed(bw)) ? aw : bw;
            fpa_pkg::CMD_MIN: res_e1 = ($signed(aw) < $signed(bw)) ? aw : bw;
            fpa_pkg::CMD_INC: res_e1 = aw + 1'b1;
            fpa_pkg::CMD_DEC: res_e1 = aw - 1'b1;
            fpa_pkg::CMD_FROM_INT:
            begin
                if ((&fi_top) || !(|fi_top))
                    res_e1 = fi_wv[W-1:0];
                else
                begin
                    res_e1  = aw[W-1] ? WMIN : WMAX;
                    stat_e1 = fpa_pkg::ST_SAT;
                end
            end
            fpa_pkg::CMD_TO_INT: res_e1 = W'($signed(aw) >>> F);
            default: res_e1 = '0;
        endcase
    end

    logic               v1_reg;
    fpa_pkg::unit_t     unit1_reg;
    logic [W-1:0]       res1_reg;
    fpa_pkg::status_t   stat1_reg;
    logic               cmp1_reg;
    logic [63:0]        prod1_reg;
    logic               neg1_reg;
    logic               dz1_reg;
    logic [NW-1:0]      num1_reg;
    logic [32:0]        den1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else
            v1_reg <= pop;
    end

    always_ff @(posedge clk)
    begin
        unit1_reg <= pop_item.unit;
        res1_reg  <= res_e1;
        stat1_reg <= stat_e1;
        cmp1_reg  <= cmp_e1;
        prod1_reg <= ma * mb;
        neg1_reg  <= sa ^ sb;
        dz1_reg   <= (mb == 32'd0);
        num1_reg  <= (NW'(ma) << (F + 1)) + NW'(mb);
        den1_reg  <= {mb, 1'b0};
    end

    // ---------------- divider ----------------
    logic [NW-1:0] quot;

    fpa_div #(
        .NW (NW)
    ) u_div (
        .clk  (clk),
        .num  (num1_reg),
        .den  (den1_reg),
        .quot (quot)
    );

    // ---------------- E2: multiply rounding ----------------
    logic [63:0]  mq;
    logic [W:0]   msat;

    always_comb
    begin
        mq   = (prod1_reg + HALF) >> F;
        msat = sat_fn(mq, neg1_reg);
    end

    logic               dl_v_reg    [DL];
    logic [W-1:0]       dl_res_reg  [DL];
    fpa_pkg::status_t   dl_stat_reg [DL];
    logic               dl_cmp_reg  [DL];
    logic               dl_div_reg  [DL];
    logic               dl_neg_reg  [DL];
    logic               dl_dz_reg   [DL];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < DL; k++)
                dl_v_reg[k] <= 1'b0;
        end
        else
        begin
            dl_v_reg[0] <= v1_reg;
            for (int k = 1; k < DL; k++)
                dl_v_reg[k] <= dl_v_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (unit1_reg == fpa_pkg::UNIT_MUL)
        begin
            dl_res_reg[0]  <= msat[W-1:0];
            dl_stat_reg[0] <= msat[W] ? fpa_pkg::ST_SAT : fpa_pkg::ST_OK;
        end
        else
        begin
            dl_res_reg[0]  <= res1_reg;
            dl_stat_reg[0] <= stat1_reg;
        end
        dl_cmp_reg[0] <= cmp1_reg;
        dl_div_reg[0] <= (unit1_reg == fpa_pkg::UNIT_DIV);
        dl_neg_reg[0] <= neg1_reg;
        dl_dz_reg[0]  <= dz1_reg;
        for (int k = 1; k < DL; k++)
        begin
            dl_res_reg[k]  <= dl_res_reg[k-1];
            dl_stat_reg[k] <= dl_stat_reg[k-1];
            dl_cmp_reg[k]  <= dl_cmp_reg[k-1];
            dl_div_reg[k]  <= dl_div_reg[k-1];
            dl_neg_reg[k]  <= dl_neg_reg[k-1];
            dl_dz_reg[k]   <= dl_dz_reg[k-1];
        end
    end

    // ---------------- final: divide merge and output register ----------------
    logic [W:0]       dsat;
    logic [W-1:0]     fin_res;
    fpa_pkg::status_t fin_stat;
    logic [31:0]      fin_res32;

    always_comb
    begin
        dsat     = sat_fn(64'(quot), dl_neg_reg[DL-1]);
        fin_res  = dl_res_reg[DL-1];
        fin_stat = dl_stat_reg[DL-1];
        if (dl_div_reg[DL-1])
        begin
            if (dl_dz_reg[DL-1])
            begin
                fin_res  = '0;
                fin_stat = fpa_pkg::ST_DIV_ZERO;
            end
            else
            begin
                fin_res  = dsat[W-1:0];
                fin_stat = dsat[W] ? fpa_pkg::ST_SAT : fpa_pkg::ST_OK;
            end
        end
    end

    generate
        if (W >= 32)
        begin : g_narrow
            assign fin_res32 = fin_res[31:0];
        end
        else
        begin : g_widen
            assign fin_res32 = 32'($signed(fin_res));
        end
    endgenerate

    logic             ov_reg;
    logic [31:0]      ores_reg;
    logic             ocmp_reg;
    fpa_pkg::status_t ostat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else
            ov_reg <= dl_v_reg[DL-1];
    end

    always_ff @(posedge clk)
    begin
        ores_reg  <= fin_res32;
        ocmp_reg  <= dl_cmp_reg[DL-1];
        ostat_reg <= fin_stat;
    end

    assign out_valid = ov_reg;
    assign out_res   = ores_reg;
    assign out_cmp   = ocmp_reg;
    assign out_stat  = ostat_reg;

    a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && ostat_reg == fpa_pkg::ST_DIV_ZERO) |-> (ores_reg == 32'd0))
        else $error("divide by zero with nonzero result");

    a_cmp_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && ocmp_reg) |-> (ores_reg == 32'd0 && ostat_reg == fpa_pkg::ST_OK))
        else $error("compare result carries value or status");

    a_align: assert property (@(posedge clk) disable iff (!rst_n)
        v1_reg |-> ##(DL) dl_v_reg[DL-1])
        else $error("side line out of step with divider");

    a_no_bubble: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> ##(NW + 2) ov_reg)
        else $error("popped word lost");

endmodule

[sv/fixed_point_alu.sv]
// ============================================================================
// fixed_point_alu
// Signed fixed-point ALU: add/sub, mul/div with rounding and saturation,
// compares, min/max, inc/dec, and integer conversions.
//
//  channel  | handshake            | ports
//  ---------+----------------------+-----------------------------------
//  command  | start / busy         | cmd, operand_a, operand_b
//  result   | valid (one cycle)    | result_raw, compare_true, status
//
// One word accepted per cycle while busy is low; each result passes the
// front register, the queue, E1, the one-bit-per-stage divider pipeline
// that all operations are aligned to, and the output register.
// Reset clears all valid flags and the queue; no item is in flight after it.
// The back end drains the queue every cycle, so busy stays low in use.
// ============================================================================
module fixed_point_alu #(
    parameter int FRAC_BITS  = 8,
    parameter int WORD_WIDTH = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [3:0]  cmd,
    input  logic [31:0] operand_a,
    input  logic [31:0] operand_b,
    output logic        valid,
    output logic [31:0] result_raw,
    output logic        compare_true,
    output logic [1:0]  status
);

    logic                         accept;
    logic                         push;
    fpa_pkg::item_t               push_item;
    logic [fpa_pkg::OPND_W-1:0]   push_a;
    logic [fpa_pkg::OPND_W-1:0]   push_b;
    logic                         pop;
    fpa_pkg::item_t               pop_item;
    logic [fpa_pkg::OPND_W-1:0]   pop_a;
    logic [fpa_pkg::OPND_W-1:0]   pop_b;
    logic [fpa_pkg::QCNT_W-1:0]   level;
    fpa_pkg::status_t             out_stat;
    logic [fpa_pkg::QCNT_W:0]     pending;

    // words in the queue plus the one in the front register
    assign pending = {1'b0, level} + {{fpa_pkg::QCNT_W{1'b0}}, push};
    assign busy    = (pending >= (fpa_pkg::QCNT_W+1)'(fpa_pkg::QUEUE_DEPTH));
    assign accept  = start && !busy;

    fpa_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .cmd       (cmd),
        .operand_a (operand_a),
        .operand_b (operand_b),
        .push      (push),
        .push_item (push_item),
        .push_a    (push_a),
        .push_b    (push_b)
    );

    fpa_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .push_a    (push_a),
        .push_b    (push_b),
        .pop       (pop),
        .pop_item  (pop_item),
        .pop_a     (pop_a),
        .pop_b     (pop_b),
        .level     (level)
    );

    fpa_back #(
        .FRAC_BITS  (FRAC_BITS),
        .WORD_WIDTH (WORD_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop       (pop),
        .pop_item  (pop_item),
        .pop_a     (pop_a),
        .pop_b     (pop_b),
        .out_valid (valid),
        .out_res   (result_raw),
        .out_cmp   (compare_true),
        .out_stat  (out_stat)
    );

    assign status = out_stat;

endmodule
